// ----- src/bdq_pkg.sv -----
// shared constants, types and ring arithmetic for the bounded deque
`timescale 1ns / 1ps

package bdq_pkg;

    // storage geometry
    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;
    localparam int POS_W  = 7;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [OP_W-1:0]          op_t;
    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [STAT_W-1:0]        stat_t;
    typedef logic [POS_W-1:0]         pos_t;

    // operation codes
    localparam op_t OP_INS_FRONT = 3'd0;
    localparam op_t OP_INS_BACK  = 3'd1;
    localparam op_t OP_DEL_FRONT = 3'd2;
    localparam op_t OP_DEL_BACK  = 3'd3;
    localparam op_t OP_SEARCH    = 3'd4;
    localparam op_t OP_REVERSE   = 3'd5;

    // result status codes
    localparam stat_t ST_DONE     = 2'd0;
    localparam stat_t ST_EMPTY    = 2'd1;
    localparam stat_t ST_FULL     = 2'd2;
    localparam stat_t ST_NOTFOUND = 2'd3;

    // modular add on ring indexes, both operands below DEPTH
    function automatic idx_t ring_add(idx_t a, idx_t b);
        logic [IDX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (IDX_W + 1)'(DEPTH))
        begin
            sum = sum - (IDX_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ----- src/bdq_if.sv -----
// request and response channel interfaces of the bounded deque
`timescale 1ns / 1ps

interface bdq_req_if import bdq_pkg::*; ();
    logic  valid;
    logic  ready;
    op_t   operation;
    data_t value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; ();
    logic  valid;
    logic  ready;
    stat_t status;
    pos_t  position;

    modport source (output valid, output status, output position, input ready);
    modport sink   (input valid, input status, input position, output ready);
endinterface

// ----- src/bdq_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- src/bounded_deque_with_search.sv -----
// Bounded deque of signed 32-bit values held in a ring RAM of DEPTH entries, with a front
// index, an entry count and a reversed flag in registers. One request is handled at a time.
// Insert, delete, reverse and unused codes pass their result through the post state to the
// output register after the request transfer. A search of a non-empty list reads one entry
// per cycle through the single RAM read port, front first, and stops at the first match or
// after the last entry. A new request is taken as soon as the previous result sits in the
// output register, even if that result is not yet taken.
// The RAM needs no clearing after reset; only slots holding list members are ever compared.
`timescale 1ns / 1ps

module bounded_deque_with_search
    import bdq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    bdq_req_if.sink  req,
    bdq_rsp_if.source rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SRCH = 2'd1;
    localparam logic [1:0] S_POST = 2'd2;

    logic [1:0] state_reg, state_next;
    idx_t       front_reg, front_next;
    cnt_t       count_reg, count_next;
    logic       rev_reg, rev_next;

    op_t        op_reg, op_next;
    data_t      value_reg, value_next;
    cnt_t       issue_reg, issue_next;
    logic       cmp_valid_reg, cmp_valid_next;
    cnt_t       cmp_pos_reg, cmp_pos_next;

    stat_t      res_status_reg, res_status_next;
    pos_t       res_pos_reg, res_pos_next;

    logic       out_valid_reg, out_valid_next;
    stat_t      out_status_reg, out_status_next;
    pos_t       out_pos_reg, out_pos_next;

    logic       mem_we;
    idx_t       mem_waddr;
    idx_t       mem_raddr;
    data_t      mem_rdata;

    logic       toward_head;
    cnt_t       rev_off;
    logic [CNT_W:0] hit_pos;

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (req.value),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.position = out_pos_reg;

    // side of the ring touched by an insert or delete
    assign toward_head = ((req.operation == OP_INS_FRONT) || (req.operation == OP_DEL_FRONT))
                         != rev_reg;

    // search slot address, walked from the logical front
    assign rev_off = count_reg - cnt_t'(1) - issue_reg;
    always_comb
    begin
        if (rev_reg)
        begin
            mem_raddr = ring_add(front_reg, rev_off[IDX_W-1:0]);
        end
        else
        begin
            mem_raddr = ring_add(front_reg, issue_reg[IDX_W-1:0]);
        end
    end

    assign hit_pos = {1'b0, cmp_pos_reg} + (CNT_W + 1)'(1);

    // request handling and search sequencing
    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        rev_next        = rev_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        issue_next      = issue_reg;
        cmp_valid_next  = 1'b0;
        cmp_pos_next    = cmp_pos_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        mem_we          = 1'b0;
        mem_waddr       = ring_add(front_reg, count_reg[IDX_W-1:0]);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = req.operation;
                    value_next      = req.value;
                    issue_next      = '0;
                    res_status_next = ST_DONE;
                    res_pos_next    = '0;
                    state_next      = S_POST;
                    case (req.operation) inside
                        OP_INS_FRONT, OP_INS_BACK:
                        begin
                            if (count_reg == cnt_t'(DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + cnt_t'(1);
                                if (toward_head)
                                begin
                                    front_next = ring_add(front_reg, idx_t'(DEPTH - 1));
                                    mem_waddr  = front_next;
                                end
                            end
                        end
                        OP_DEL_FRONT, OP_DEL_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - cnt_t'(1);
                                if (toward_head)
                                begin
                                    front_next = ring_add(front_reg, idx_t'(1));
                                end
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SRCH;
                            end
                        end
                        OP_REVERSE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rev_next = !rev_reg;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_SRCH:
            begin
                // issue one read per cycle while entries remain
                if (issue_reg < count_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_pos_next   = issue_reg;
                    issue_next     = issue_reg + cnt_t'(1);
                end
                // compare the entry read in the previous cycle
                if (cmp_valid_reg)
                begin
                    if (mem_rdata == value_reg)
                    begin
                        // first match ends the walk, drop the read already issued
                        cmp_valid_next  = 1'b0;
                        res_status_next = ST_DONE;
                        res_pos_next    = POS_W'(hit_pos);
                        state_next      = S_POST;
                    end
                    else if (cmp_pos_reg == count_reg - cnt_t'(1))
                    begin
                        res_status_next = ST_NOTFOUND;
                        res_pos_next    = '0;
                        state_next      = S_POST;
                    end
                end
            end
            S_POST:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_POST) && (!out_valid_reg || rsp.ready))
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_pos_next    = res_pos_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        issue_reg      <= issue_next;
        cmp_pos_reg    <= cmp_pos_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
    end

`ifndef SYNTHESIS
    // entry count stays within the ring size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(DEPTH))
        else $error("entry count above depth");

    // list geometry changes only after a request transfer
    a_geom_change: assert property (@(posedge clk) disable iff (!rst_n)
        (!$stable(count_reg) || !$stable(front_reg) || !$stable(rev_reg))
            |-> $past(req.valid && req.ready))
        else $error("list state changed without a request transfer");

    // a compare in flight always refers to a live list position
    a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> (state_reg == S_SRCH) && (cmp_pos_reg < count_reg))
        else $error("search compare outside the list");

    // a posted result reaches the output register in the next cycle
    a_post_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POST) && (!out_valid_reg || rsp.ready)
            |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("posted result not loaded");

    // searches only run on the operation that asked for them
    a_search_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH) |-> (op_reg == OP_SEARCH) && (count_reg != '0))
        else $error("search running without a search request");
`endif

endmodule

// ----- verif/bdq_checker.sv -----
// checker for the bounded deque: models the list and compares each response transfer
`timescale 1ns / 1ps

module bdq_checker
    import bdq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    bdq_req_if   req,
    bdq_rsp_if   rsp,
    output int   errors,
    output int   outstanding,
    output int   checked,
    output int   full_drops,
    output int   empty_hits,
    output int   search_hits,
    output int   search_misses
);

    typedef struct packed {
        stat_t status;
        pos_t  position;
    } outcome_t;

    // shadow copy of the list
    data_t    entries [DEPTH];
    idx_t     head;
    cnt_t     fill;
    logic     flipped;
    outcome_t expected_q [$];

    function automatic idx_t wrap_slot(int unsigned slot);
        return idx_t'(slot % DEPTH);
    endfunction

    // apply one request to the shadow list and return the response it must produce
    function automatic outcome_t apply_op(op_t op, data_t v);
        outcome_t    r;
        int unsigned slot;
        logic        hit;
        r.status   = ST_DONE;
        r.position = '0;
        hit        = 1'b0;
        case (op)
            OP_INS_FRONT, OP_INS_BACK:
            begin
                if (int'(fill) >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // logical front is the physical back while reversed
                    if ((op == OP_INS_FRONT) != flipped)
                    begin
                        head = wrap_slot(int'(head) + DEPTH - 1);
                        slot = int'(head);
                    end
                    else
                    begin
                        slot = int'(head) + int'(fill);
                    end
                    entries[wrap_slot(slot)] = v;
                    fill = fill + cnt_t'(1);
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK:
            begin
                if (fill == '0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    if ((op == OP_DEL_FRONT) != flipped)
                    begin
                        head = wrap_slot(int'(head) + 1);
                    end
                    fill = fill - cnt_t'(1);
                end
            end
            OP_SEARCH:
            begin
                if (fill == '0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    // first match counted from the logical front
                    r.status = ST_NOTFOUND;
                    for (int p = 0; p < int'(fill) && !hit; p++)
                    begin
                        slot = flipped ? int'(head) + int'(fill) - 1 - p : int'(head) + p;
                        if (entries[wrap_slot(slot)] == v)
                        begin
                            hit        = 1'b1;
                            r.status   = ST_DONE;
                            r.position = pos_t'(p + 1);
                        end
                    end
                end
            end
            OP_REVERSE:
            begin
                if (fill == '0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    flipped = !flipped;
                end
            end
            default:
            begin
                // unused codes leave the list alone
            end
        endcase
        return r;
    endfunction

    // predict on request transfers, compare on response transfers
    always @(posedge clk or negedge rst_n)
    begin : monitor
        outcome_t want;
        int       fails;
        if (!rst_n)
        begin
            head    = '0;
            fill    = '0;
            flipped = 1'b0;
            expected_q.delete();
            errors        <= 0;
            outstanding   <= 0;
            checked       <= 0;
            full_drops    <= 0;
            empty_hits    <= 0;
            search_hits   <= 0;
            search_misses <= 0;
        end
        else
        begin
            fails = 0;
            if (req.valid && req.ready)
            begin
                expected_q.push_back(apply_op(req.operation, req.value));
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("response transfer with nothing expected: status %0d position %0d",
                           rsp.status, rsp.position);
                    fails++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d", want.status, rsp.status);
                        fails++;
                    end
                    if (rsp.position !== want.position)
                    begin
                        $error("position mismatch: expected %0d, got %0d",
                               want.position, rsp.position);
                        fails++;
                    end
                    checked <= checked + 1;
                    if (want.status == ST_FULL)
                    begin
                        full_drops <= full_drops + 1;
                    end
                    if (want.status == ST_EMPTY)
                    begin
                        empty_hits <= empty_hits + 1;
                    end
                    if (want.status == ST_NOTFOUND)
                    begin
                        search_misses <= search_misses + 1;
                    end
                    if (want.status == ST_DONE && want.position != '0)
                    begin
                        search_hits <= search_hits + 1;
                    end
                end
            end
            errors      <= errors + fails;
            outstanding <= expected_q.size();
        end
    end

endmodule

// ----- verif/tb_bounded_deque_with_search.sv -----
// testbench top for the bounded deque: stimulus, response backpressure and verdict
`timescale 1ns / 1ps

module tb_bounded_deque_with_search;
    import bdq_pkg::*;

    // codes the block must ignore
    localparam op_t OP_SPARE_A = 3'd6;
    localparam op_t OP_SPARE_B = 3'd7;

    localparam data_t VAL_MIN = data_t'(32'h8000_0000);
    localparam data_t VAL_MAX = data_t'(32'h7fff_ffff);

    localparam int RANDOM_ITEMS = 800;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = DEPTH + 8;

    logic clk;
    logic rst_n;

    bdq_req_if req_ch ();
    bdq_rsp_if rsp_ch ();

    int errors;
    int outstanding;
    int checked;
    int full_drops;
    int empty_hits;
    int search_hits;
    int search_misses;

    int    sent;
    int    directed_cnt;
    int    burst_left;
    int    hold_req_cnt;
    int    hold_count;
    data_t value_pool [8];

    bounded_deque_with_search i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bdq_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .errors        (errors),
        .outstanding   (outstanding),
        .checked       (checked),
        .full_drops    (full_drops),
        .empty_hits    (empty_hits),
        .search_hits   (search_hits),
        .search_misses (search_misses)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #4ms;
        $display("FAILURE");
        $finish;
    end

    // mostly pool values so searches hit and duplicates occur, the rest fully random
    function automatic data_t pick_value();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 6)
        begin
            return value_pool[$urandom_range(7)];
        end
        return data_t'($urandom);
    endfunction

    function automatic op_t pick_op(int ins_pct, int del_pct);
        int r;
        r = int'($urandom_range(99));
        if (r < 3)
        begin
            return ($urandom_range(1) == 0) ? OP_SPARE_A : OP_SPARE_B;
        end
        if (r < 3 + ins_pct)
        begin
            return ($urandom_range(1) == 0) ? OP_INS_FRONT : OP_INS_BACK;
        end
        if (r < 3 + ins_pct + del_pct)
        begin
            return ($urandom_range(1) == 0) ? OP_DEL_FRONT : OP_DEL_BACK;
        end
        return ($urandom_range(3) == 0) ? OP_REVERSE : OP_SEARCH;
    endfunction

    // offer one request until its transfer, then idle if the burst is over
    task automatic push_item(input op_t op, input data_t v);
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.value     <= v;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
        end
    endtask

    // stop offering until every pending response has come back
    task automatic drain_wait();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    // response side: stall pattern with occasional long hold-offs on request
    initial
    begin : receiver
        int run_left;
        int stall_mode;
        int hold_seen;
        run_left   = 0;
        stall_mode = 0;
        hold_seen  = 0;
        hold_count = 0;
        forever
        begin
            if (hold_seen != hold_req_cnt)
            begin
                hold_seen = hold_req_cnt;
                hold_count++;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (run_left == 0)
                begin
                    stall_mode = $urandom_range(2);
                    run_left   = $urandom_range(20, 80);
                end
                run_left--;
                case (stall_mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(9) < 7);
                    default: rsp_ch.ready <= ($urandom_range(9) < 3);
                endcase
                @(posedge clk);
            end
        end
    end

    // request side
    initial
    begin : stimulus
        int phase;
        int ins_pct;
        int del_pct;
        int span;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_INS_FRONT;
        req_ch.value     = '0;
        value_pool       = '{32'sd0, 32'sd1, -32'sd1, VAL_MIN, VAL_MAX,
                             data_t'(32'h5a5a_5a5a), data_t'(32'ha5a5_a5a5), 32'sd100};
        sent             = 0;
        burst_left       = 8;
        hold_req_cnt     = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every removal, search and reverse reports empty; spare codes ignored
        push_item(OP_DEL_FRONT, 32'sd0);
        push_item(OP_DEL_BACK, 32'sd0);
        push_item(OP_SEARCH, 32'sd0);
        push_item(OP_REVERSE, 32'sd0);
        push_item(OP_SPARE_A, data_t'($urandom));
        push_item(OP_SPARE_B, data_t'($urandom));
        // single entry, reversed
        push_item(OP_INS_BACK, 32'sd42);
        push_item(OP_REVERSE, 32'sd0);
        push_item(OP_SEARCH, 32'sd42);
        push_item(OP_DEL_BACK, 32'sd0);
        // value extremes, then a search miss and searches across a reverse
        push_item(OP_INS_FRONT, VAL_MIN);
        push_item(OP_INS_BACK, VAL_MAX);
        push_item(OP_INS_FRONT, 32'sd0);
        push_item(OP_INS_BACK, -32'sd1);
        push_item(OP_SEARCH, VAL_MAX);
        push_item(OP_SEARCH, 32'sd1);
        push_item(OP_REVERSE, 32'sd0);
        push_item(OP_SEARCH, 32'sd0);
        // duplicate value: first match from the front wins
        push_item(OP_INS_FRONT, 32'sd0);
        push_item(OP_SEARCH, 32'sd0);
        push_item(OP_INS_BACK, 32'sd7);
        push_item(OP_DEL_FRONT, 32'sd0);
        push_item(OP_DEL_BACK, 32'sd0);
        push_item(OP_REVERSE, 32'sd0);
        push_item(OP_SEARCH, VAL_MIN);
        directed_cnt = sent;
        drain_wait();

        // random phases cycling through filling, mixed and draining mixes
        phase = 0;
        while (sent - directed_cnt < RANDOM_ITEMS)
        begin
            case (phase % 3)
                0:
                begin
                    ins_pct = 75;
                    del_pct = 10;
                    span    = $urandom_range(100, 160);
                end
                1:
                begin
                    ins_pct = 40;
                    del_pct = 35;
                    span    = $urandom_range(40, 120);
                end
                default:
                begin
                    ins_pct = 10;
                    del_pct = 75;
                    span    = $urandom_range(60, 120);
                end
            endcase
            // long receiver hold-off right after a fill, while requests keep coming
            if (phase == 1 || phase == 4)
            begin
                hold_req_cnt <= hold_req_cnt + 1;
            end
            for (int k = 0; k < span && sent - directed_cnt < RANDOM_ITEMS; k++)
            begin
                push_item(pick_op(ins_pct, del_pct), pick_value());
            end
            if (phase == 0 || $urandom_range(1) == 1)
            begin
                drain_wait();
            end
            phase++;
        end

        drain_wait();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d requests (%0d directed) and %0d checked responses",
                 sent, directed_cnt, checked);
        $display("seen: %0d full drops, %0d empty reports, %0d search hits, %0d misses, %0d holds",
                 full_drops, empty_hits, search_hits, search_misses, hold_count);
        if (errors == 0 && outstanding == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
